// ===== design/gmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gmc_pkg
// Shared types and constants for the gate motor controller.
// ----------------------------------------------------------------------------
package gmc_pkg;

  typedef enum logic [2:0] {
    MODE_OPEN    = 3'd0,
    MODE_OPENING = 3'd1,
    MODE_CLOSED  = 3'd2,
    MODE_CLOSING = 3'd3,
    MODE_HALTED  = 3'd4,
    MODE_FAULT   = 3'd5,
    MODE_SYNC    = 3'd6
  } mode_t;

  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned BLINK_W = 4;
  localparam int unsigned CFG_W   = 16;

  localparam logic REG_IDLE_TIMEOUT = 1'b0;
  localparam logic REG_BLINK_TICKS  = 1'b1;

  localparam logic [IDLE_W-1:0]  IDLE_TIMEOUT_RST = 16'd6000;
  localparam logic [BLINK_W-1:0] BLINK_TICKS_RST  = 4'd6;
  localparam logic [IDLE_W-1:0]  IDLE_MAX         = 16'hFFFF;
  localparam logic [BLINK_W-1:0] BLINK_MAX        = 4'hF;

endpackage
`default_nettype wire

// ===== design/gate_motor_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gate_motor_controller
// Motorized gate mode machine evaluated once per tick transaction.
//
// Usage: each input transaction on in_* is one control tick carrying the
// open and close commands, both end switches and the obstacle beam. For
// every input transaction exactly one output transaction appears on out_*
// with the motor drive pair, buzzer, lamp and the new gate mode code.
// The result is registered at the edge that accepts the tick and is valid
// from the next cycle. Throughput is one transaction per cycle while the
// output is not stalled; the mode, idle and blink update is combinational
// logic feeding the result register. When out_stall is high with a result
// held, it stays put and in_stall rises so no tick is taken until it is consumed.
// Reset (rst_n low, synchronous) sets the mode and prior mode to halted,
// clears the idle count and blink level, presets the blink count to its
// maximum, loads the register defaults and empties the output register.
// Registers are written through cfg_wr_en / cfg_index / cfg_wdata; the user writes them only while idle (not enforced).
// ----------------------------------------------------------------------------
module gate_motor_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd_open,
  input  wire logic        in_cmd_close,
  input  wire logic        in_at_open_end,
  input  wire logic        in_at_close_end,
  input  wire logic        in_beam_blocked,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_drive_open,
  output logic             out_drive_close,
  output logic             out_buzzer,
  output logic             out_lamp,
  output logic [2:0]       out_gate_code
);

  logic [gmc_pkg::IDLE_W-1:0]  idle_timeout_r;
  logic [gmc_pkg::BLINK_W-1:0] blink_ticks_r;

  gmc_pkg::mode_t              mode_r, mode_nxt;
  gmc_pkg::mode_t              prior_r, prior_nxt;
  logic [gmc_pkg::IDLE_W-1:0]  idle_r, idle_nxt;
  logic [gmc_pkg::BLINK_W-1:0] blink_cnt_r, blink_cnt_nxt;
  logic                        blink_lvl_r, blink_lvl_nxt;

  logic                        out_valid_r;
  logic                        drv_open_r, drv_open_nxt;
  logic                        drv_close_r, drv_close_nxt;
  logic                        buz_r, buz_nxt;
  gmc_pkg::mode_t              code_r;

  logic                        accept;
  logic                        any_cmd;
  logic                        timeout;
  logic [gmc_pkg::IDLE_W-1:0]  idle_inc;
  logic [gmc_pkg::BLINK_W-1:0] blink_inc;
  gmc_pkg::mode_t              mode_eff;
  gmc_pkg::mode_t              prior_eff;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign any_cmd  = in_cmd_open | in_cmd_close;

  always_comb begin
    // idle count
    if (any_cmd) begin
      idle_inc = '0;
    end else if (idle_r != gmc_pkg::IDLE_MAX) begin
      idle_inc = idle_r + 1'b1;
    end else begin
      idle_inc = idle_r;
    end

    // resync on timeout
    timeout   = (idle_inc > idle_timeout_r) && (mode_r != gmc_pkg::MODE_SYNC);
    mode_eff  = timeout ? gmc_pkg::MODE_SYNC : mode_r;
    prior_eff = timeout ? mode_r : prior_r;

    mode_nxt      = mode_eff;
    prior_nxt     = prior_eff;
    idle_nxt      = idle_inc;
    drv_open_nxt  = 1'b0;
    drv_close_nxt = 1'b0;

    case (mode_eff)
      gmc_pkg::MODE_OPEN: begin
        if (in_cmd_close) begin
          mode_nxt  = gmc_pkg::MODE_CLOSING;
          prior_nxt = mode_eff;
          idle_nxt  = '0;
        end
      end
      gmc_pkg::MODE_CLOSED: begin
        if (in_cmd_open) begin
          mode_nxt  = gmc_pkg::MODE_OPENING;
          prior_nxt = mode_eff;
          idle_nxt  = '0;
        end
      end
      gmc_pkg::MODE_OPENING: begin
        drv_open_nxt = 1'b1;
        if (in_at_open_end) begin
          mode_nxt  = gmc_pkg::MODE_OPEN;
          prior_nxt = mode_eff;
        end else if (in_cmd_close) begin
          mode_nxt  = gmc_pkg::MODE_HALTED;
          prior_nxt = mode_eff;
        end
      end
      gmc_pkg::MODE_CLOSING: begin
        drv_close_nxt = 1'b1;
        if (in_beam_blocked) begin
          mode_nxt  = gmc_pkg::MODE_HALTED;
          prior_nxt = mode_eff;
        end else if (in_at_close_end) begin
          mode_nxt  = gmc_pkg::MODE_CLOSED;
          prior_nxt = mode_eff;
        end else if (in_cmd_open) begin
          mode_nxt  = gmc_pkg::MODE_HALTED;
          prior_nxt = mode_eff;
        end
      end
      gmc_pkg::MODE_HALTED: begin
        if (in_cmd_open) begin
          mode_nxt  = gmc_pkg::MODE_OPENING;
          prior_nxt = mode_eff;
        end else if (in_cmd_close) begin
          mode_nxt  = gmc_pkg::MODE_CLOSING;
          prior_nxt = mode_eff;
        end
      end
      gmc_pkg::MODE_SYNC: begin
        if (in_at_open_end) begin
          mode_nxt = gmc_pkg::MODE_OPEN;
        end else if (in_at_close_end) begin
          mode_nxt = gmc_pkg::MODE_CLOSED;
        end else begin
          mode_nxt  = gmc_pkg::MODE_FAULT;
          prior_nxt = mode_eff;
        end
        idle_nxt = '0;
      end
      gmc_pkg::MODE_FAULT: begin
        if (prior_eff == gmc_pkg::MODE_CLOSING) begin
          mode_nxt = gmc_pkg::MODE_OPENING;
        end else if (prior_eff == gmc_pkg::MODE_OPENING) begin
          mode_nxt = gmc_pkg::MODE_CLOSING;
        end else begin
          mode_nxt = gmc_pkg::MODE_HALTED;
        end
      end
      default: begin
        mode_nxt  = gmc_pkg::MODE_HALTED;
        prior_nxt = mode_eff;
      end
    endcase

    // warning blink
    blink_inc     = (blink_cnt_r != gmc_pkg::BLINK_MAX) ? blink_cnt_r + 1'b1 : blink_cnt_r;
    blink_cnt_nxt = blink_inc;
    blink_lvl_nxt = blink_lvl_r;
    buz_nxt       = 1'b0;
    if (mode_nxt == gmc_pkg::MODE_CLOSING) begin
      if (blink_inc > blink_ticks_r) begin
        blink_lvl_nxt = ~blink_lvl_r;
        blink_cnt_nxt = '0;
      end
      buz_nxt = blink_lvl_nxt;
    end else if (mode_nxt == gmc_pkg::MODE_FAULT) begin
      buz_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= gmc_pkg::IDLE_TIMEOUT_RST;
      blink_ticks_r  <= gmc_pkg::BLINK_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gmc_pkg::REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        gmc_pkg::REG_BLINK_TICKS:  blink_ticks_r  <= cfg_wdata[gmc_pkg::BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= gmc_pkg::MODE_HALTED;
      prior_r     <= gmc_pkg::MODE_HALTED;
      idle_r      <= '0;
      blink_cnt_r <= gmc_pkg::BLINK_MAX;
      blink_lvl_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        prior_r     <= prior_nxt;
        idle_r      <= idle_nxt;
        blink_cnt_r <= blink_cnt_nxt;
        blink_lvl_r <= blink_lvl_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drv_open_r  <= drv_open_nxt;
      drv_close_r <= drv_close_nxt;
      buz_r       <= buz_nxt;
      code_r      <= mode_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_open  = drv_open_r;
  assign out_drive_close = drv_close_r;
  assign out_buzzer      = buz_r;
  assign out_lamp        = buz_r;
  assign out_gate_code   = code_r;

endmodule
`default_nettype wire
